>>> hdl/market_by_participant_order_book_defines.svh
// Assertion macros for the market-by-participant order book
`ifndef MARKET_BY_PARTICIPANT_ORDER_BOOK_DEFINES_SVH
`define MARKET_BY_PARTICIPANT_ORDER_BOOK_DEFINES_SVH

// Same-cycle implication
`define MBP_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("order book assertion failed");

// Next-cycle implication
`define MBP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("order book assertion failed");

`endif

>>> hdl/mbpob_pkg.sv
// Shared constants, codes and types of the order book
package mbpob_pkg;

	localparam int SYMBOLS   = 16;
	localparam int ENTRIES   = 32;
	localparam int SYM_IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int ENT_W     = $clog2(ENTRIES);
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int ADDR_W    = SYM_IDX_W + 1 + ENT_W;
	localparam int SLOTS     = 2 ** ADDR_W;

	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_EXEC    = 2'd1;
	localparam logic [1:0] CMD_CANCEL  = 2'd2;
	localparam logic [1:0] CMD_REPLACE = 2'd3;

	localparam logic [2:0] ST_DONE       = 3'd0;
	localparam logic [2:0] ST_ZERO_PRICE = 3'd1;
	localparam logic [2:0] ST_ZERO_QTY   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
	localparam logic [2:0] ST_FULL       = 3'd4;

	localparam logic [1:0] TICK_FLAT = 2'd0;
	localparam logic [1:0] TICK_UP   = 2'd1;
	localparam logic [1:0] TICK_DOWN = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  symbol;
		logic        side;
		logic [31:0] price;
		logic [31:0] quantity;
		logic [31:0] participant;
		logic [31:0] old_price;
		logic [31:0] old_quantity;
		logic        skip;
		logic        oor;
		logic [2:0]  pre_status;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  book_symbol;
		logic [5:0]  bid_entries;
		logic [5:0]  ask_entries;
		logic [31:0] last_price;
		logic [31:0] open_price;
		logic [31:0] high_price;
		logic [31:0] low_price;
		logic [1:0]  tick;
		logic [31:0] trade_count;
		logic [63:0] total_volume;
		logic [63:0] notional_sum;
	} res_t;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] who;
		logic [31:0] qty;
		logic [15:0] orders;
	} entry_t;

endpackage

>>> hdl/mbpob_front.sv
// Front end: classifies incoming messages and queues them for the engine
module mbpob_front import mbpob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [3:0]  symbol,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] participant,
	input  logic [31:0] old_price,
	input  logic [31:0] old_quantity,
	output logic        q_empty,
	input  logic        q_pop,
	output cmd_t        q_head
);

	cmd_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       wr, rd;

	always_comb begin
		cls.command      = command;
		cls.symbol       = symbol;
		cls.side         = side;
		cls.price        = price;
		cls.quantity     = quantity;
		cls.participant  = participant;
		cls.old_price    = old_price;
		cls.old_quantity = old_quantity;
		cls.oor          = int'(symbol) >= SYMBOLS;
		cls.skip         = cls.oor || (price == '0) ||
			((command == CMD_ADD) && (quantity == '0));
		if (cls.oor) begin
			cls.pre_status = ST_NOT_FOUND;
		end else if (price == '0) begin
			cls.pre_status = ST_ZERO_PRICE;
		end else begin
			cls.pre_status = ST_ZERO_QTY;
		end
	end

	assign full    = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign q_head  = slot_q[rp_q];
	assign wr      = push && !full;
	assign rd      = q_pop && !q_empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

>>> hdl/mbpob_resq.sv
// Result queue between the engine and the result port
module mbpob_resq import mbpob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic res_push,
	input  res_t res_data,
	output logic res_full,
	output logic empty,
	input  logic pop,
	output res_t head
);

	res_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign res_full = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign head     = slot_q[rp_q];
	assign wr       = res_push && !res_full;
	assign rd       = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= !wp_q;
			end
			if (rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

>>> hdl/mbpob_engine.sv
// Back end: book sequencer over the entry memory and per-symbol trade statistics
module mbpob_engine import mbpob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic market_open,
	input  logic q_empty,
	output logic q_pop,
	input  cmd_t q_head,
	input  logic res_full,
	output logic res_push,
	output res_t res_data
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_START    = 4'd1;
	localparam logic [3:0] S_SCAN_RD  = 4'd2;
	localparam logic [3:0] S_SCAN_EV  = 4'd3;
	localparam logic [3:0] S_DECIDE   = 4'd4;
	localparam logic [3:0] S_SHIFT_RD = 4'd5;
	localparam logic [3:0] S_SHIFT_WR = 4'd6;
	localparam logic [3:0] S_INS      = 4'd7;
	localparam logic [3:0] S_FIN      = 4'd8;
	localparam logic [3:0] S_REPORT   = 4'd9;

	logic [3:0]       state_q;
	cmd_t             cur_q;
	logic             op_add_q, then_add_q, up_q;
	logic [31:0]      opp_q, opq_q;
	logic [CNT_W-1:0] i_q, n_q, k_q, pos_q;
	logic             found_q, posf_q;
	logic [31:0]      kq_q;
	logic [15:0]      kc_q;
	logic [2:0]       stat_q, op_stat_q;

	entry_t            mem [SLOTS];
	entry_t            rd_q, wdata;
	logic [ADDR_W-1:0] raddr, waddr;
	logic              we;

	logic [CNT_W-1:0] bid_fill_q [SYMBOLS];
	logic [CNT_W-1:0] ask_fill_q [SYMBOLS];

	logic [31:0] last_q [SYMBOLS];
	logic [31:0] open_q [SYMBOLS];
	logic [31:0] high_q [SYMBOLS];
	logic [31:0] low_q  [SYMBOLS];
	logic [1:0]  tick_q [SYMBOLS];
	logic [31:0] tcnt_q [SYMBOLS];
	logic [63:0] vol_q  [SYMBOLS];
	logic [63:0] notl_q [SYMBOLS];

	logic                 go_s1;
	logic [SYM_IDX_W-1:0] sym_s1;
	logic [31:0]          px_s1, qty_s1;
	logic [63:0]          prod_s1;

	logic [SYM_IDX_W-1:0] sym;
	logic [SYM_IDX_W:0]   book;
	logic [CNT_W-1:0]     fill_cur, pos_eff;
	logic                 rm, hit, ahead;
	logic [32:0]          qsum;
	logic [64:0]          vsum, nsum;
	logic                 stat_go;

	function automatic logic [ADDR_W-1:0] slot(input logic [SYM_IDX_W:0] bk,
		input logic [CNT_W-1:0] idx);
		return {bk, idx[ENT_W-1:0]};
	endfunction

	assign sym      = SYM_IDX_W'(cur_q.symbol);
	assign book     = {sym, cur_q.side};
	assign fill_cur = cur_q.side ? ask_fill_q[sym] : bid_fill_q[sym];
	assign pos_eff  = posf_q ? pos_q : n_q;
	assign rm       = kq_q <= opq_q;
	assign qsum     = {1'b0, kq_q} + {1'b0, opq_q};
	assign hit      = (rd_q.price == opp_q) && (rd_q.who == cur_q.participant);
	assign ahead    = cur_q.side ? (opp_q < rd_q.price) : (opp_q > rd_q.price);
	assign stat_go  = (state_q == S_IDLE) && !q_empty && !q_head.skip &&
		(q_head.command == CMD_EXEC);

	always_comb begin
		q_pop    = (state_q == S_IDLE) && !q_empty;
		res_push = (state_q == S_REPORT) && !go_s1;
		we       = 1'b0;
		waddr    = slot(book, k_q);
		wdata    = '{opp_q, cur_q.participant, kq_q - opq_q, kc_q};
		raddr    = slot(book, i_q);
		unique case (state_q)
			S_DECIDE: begin
				if (!op_add_q) begin
					we = found_q && !rm;
				end else begin
					we          = found_q && (opq_q != '0);
					wdata.qty   = qsum[32] ? '1 : qsum[31:0];
					wdata.orders = (kc_q == '1) ? kc_q : kc_q + 16'd1;
				end
			end
			S_SHIFT_RD: begin
				raddr = up_q ? slot(book, i_q + 1'b1) : slot(book, i_q - 1'b1);
			end
			S_SHIFT_WR: begin
				we    = 1'b1;
				waddr = slot(book, i_q);
				wdata = rd_q;
			end
			S_INS: begin
				we    = 1'b1;
				waddr = slot(book, pos_q);
				wdata = '{opp_q, cur_q.participant, opq_q, 16'd1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= q_head;
				if (q_head.command == CMD_ADD) begin
					opp_q <= q_head.price;
					opq_q <= q_head.quantity;
				end else if (q_head.command == CMD_REPLACE) begin
					opp_q <= q_head.old_price;
					opq_q <= q_head.old_quantity;
				end else begin
					opp_q <= q_head.price;
					opq_q <= q_head.quantity;
				end
			end
			S_START: begin
				n_q <= fill_cur;
				i_q <= '0;
			end
			S_SCAN_EV: begin
				i_q <= i_q + 1'b1;
				if (hit && !found_q) begin
					k_q  <= i_q;
					kq_q <= rd_q.qty;
					kc_q <= rd_q.orders;
				end
				if (ahead && !posf_q) begin
					pos_q <= i_q;
				end
			end
			S_DECIDE: begin
				if (!op_add_q) begin
					i_q <= k_q;
				end else begin
					i_q   <= n_q;
					pos_q <= pos_eff;
				end
			end
			S_SHIFT_WR: begin
				i_q <= up_q ? i_q + 1'b1 : i_q - 1'b1;
			end
			S_FIN: begin
				if (!op_add_q && then_add_q) begin
					opp_q <= cur_q.price;
					opq_q <= cur_q.quantity;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_add_q   <= 1'b0;
			then_add_q <= 1'b0;
			up_q       <= 1'b0;
			found_q    <= 1'b0;
			posf_q     <= 1'b0;
			stat_q     <= ST_DONE;
			op_stat_q  <= ST_DONE;
			for (int s = 0; s < SYMBOLS; s++) begin
				bid_fill_q[s] <= '0;
				ask_fill_q[s] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						if (q_head.skip) begin
							stat_q  <= q_head.pre_status;
							state_q <= S_REPORT;
						end else begin
							stat_q     <= ST_DONE;
							op_add_q   <= q_head.command == CMD_ADD;
							then_add_q <= q_head.command == CMD_REPLACE;
							state_q    <= S_START;
						end
					end
				end
				S_START: begin
					found_q <= 1'b0;
					posf_q  <= 1'b0;
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					state_q <= (i_q == n_q) ? S_DECIDE : S_SCAN_EV;
				end
				S_SCAN_EV: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (ahead) begin
						posf_q <= 1'b1;
					end
					state_q <= S_SCAN_RD;
				end
				S_DECIDE: begin
					op_stat_q <= ST_DONE;
					state_q   <= S_FIN;
					if (!op_add_q) begin
						if (!found_q) begin
							op_stat_q <= ST_NOT_FOUND;
						end else if (rm) begin
							if (cur_q.side) begin
								ask_fill_q[sym] <= n_q - 1'b1;
							end else begin
								bid_fill_q[sym] <= n_q - 1'b1;
							end
							if (k_q + 1'b1 < n_q) begin
								up_q    <= 1'b1;
								state_q <= S_SHIFT_RD;
							end
						end
					end else if (opq_q == '0) begin
						op_stat_q <= ST_ZERO_QTY;
					end else if (!found_q) begin
						if (int'(n_q) >= ENTRIES) begin
							op_stat_q <= ST_FULL;
						end else begin
							if (cur_q.side) begin
								ask_fill_q[sym] <= n_q + 1'b1;
							end else begin
								bid_fill_q[sym] <= n_q + 1'b1;
							end
							up_q    <= 1'b0;
							state_q <= (n_q > pos_eff) ? S_SHIFT_RD : S_INS;
						end
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (up_q) begin
						state_q <= (i_q + 1'b1 == n_q - 1'b1) ? S_FIN : S_SHIFT_RD;
					end else begin
						state_q <= (i_q - 1'b1 == pos_q) ? S_INS : S_SHIFT_RD;
					end
				end
				S_INS: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (op_add_q) begin
						if ((op_stat_q != ST_DONE) || !cur_q.command[0] ||
							cur_q.command[1] == 1'b0) begin
							stat_q <= op_stat_q;
						end
						state_q <= S_REPORT;
					end else begin
						stat_q <= op_stat_q;
						if (then_add_q) begin
							op_add_q   <= 1'b1;
							then_add_q <= 1'b0;
							state_q    <= S_START;
						end else begin
							state_q <= S_REPORT;
						end
					end
				end
				S_REPORT: begin
					if (!res_full && !go_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		sym_s1  <= SYM_IDX_W'(q_head.symbol);
		px_s1   <= q_head.price;
		qty_s1  <= q_head.quantity;
		prod_s1 <= 64'(q_head.price) * 64'(q_head.quantity);
	end

	assign vsum = {1'b0, vol_q[sym_s1]} + {33'd0, qty_s1};
	assign nsum = {1'b0, notl_q[sym_s1]} + {1'b0, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			for (int s = 0; s < SYMBOLS; s++) begin
				last_q[s] <= '0;
				open_q[s] <= '0;
				high_q[s] <= '0;
				low_q[s]  <= '0;
				tick_q[s] <= TICK_FLAT;
				tcnt_q[s] <= '0;
				vol_q[s]  <= '0;
				notl_q[s] <= '0;
			end
		end else begin
			go_s1 <= stat_go;
			if (go_s1) begin
				if (px_s1 > last_q[sym_s1]) begin
					tick_q[sym_s1] <= TICK_UP;
				end else if (px_s1 < last_q[sym_s1]) begin
					tick_q[sym_s1] <= TICK_DOWN;
				end else begin
					tick_q[sym_s1] <= TICK_FLAT;
				end
				last_q[sym_s1] <= px_s1;
				if (market_open && (open_q[sym_s1] == '0)) begin
					open_q[sym_s1] <= px_s1;
				end
				if (high_q[sym_s1] < px_s1) begin
					high_q[sym_s1] <= px_s1;
				end
				if ((low_q[sym_s1] == '0) || (low_q[sym_s1] > px_s1)) begin
					low_q[sym_s1] <= px_s1;
				end
				if (tcnt_q[sym_s1] != '1) begin
					tcnt_q[sym_s1] <= tcnt_q[sym_s1] + 32'd1;
				end
				vol_q[sym_s1]  <= vsum[64] ? '1 : vsum[63:0];
				notl_q[sym_s1] <= nsum[64] ? '1 : nsum[63:0];
			end
		end
	end

	always_comb begin
		res_data             = '0;
		res_data.status      = stat_q;
		res_data.book_symbol = cur_q.symbol;
		if (!cur_q.oor) begin
			res_data.bid_entries  = 6'(bid_fill_q[sym]);
			res_data.ask_entries  = 6'(ask_fill_q[sym]);
			res_data.last_price   = last_q[sym];
			res_data.open_price   = open_q[sym];
			res_data.high_price   = high_q[sym];
			res_data.low_price    = low_q[sym];
			res_data.tick         = tick_q[sym];
			res_data.trade_count  = tcnt_q[sym];
			res_data.total_volume = vol_q[sym];
			res_data.notional_sum = notl_q[sym];
		end
	end

endmodule

>>> hdl/market_by_participant_order_book.sv
// Top level of the market-by-participant order book
//
//   channel   handshake              payload
//   input     push / full            command .. old_quantity
//   result    empty / pop            status .. notional_sum
//   config    cfg_valid / cfg_ready  cfg_data (market_open)
//
// An item's time grows with the entries on its book side, since the engine
// walks the entry memory (one read port, one write port) to scan them.
// Inserts and removals also move each entry behind the slot; replace runs both walks.
// Reset clears fills and statistics at once; entries need no clearing.
// The two-deep queues on either side let input and result stall independently.
`include "market_by_participant_order_book_defines.svh"
module market_by_participant_order_book import mbpob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [3:0]  symbol,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [31:0] participant,
	input  logic [31:0] old_price,
	input  logic [31:0] old_quantity,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [3:0]  book_symbol,
	output logic [5:0]  bid_entries,
	output logic [5:0]  ask_entries,
	output logic [31:0] last_price,
	output logic [31:0] open_price,
	output logic [31:0] high_price,
	output logic [31:0] low_price,
	output logic [1:0]  tick,
	output logic [31:0] trade_count,
	output logic [63:0] total_volume,
	output logic [63:0] notional_sum,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	logic market_open_q;
	logic q_empty, q_pop, res_push, res_full;
	cmd_t q_head;
	res_t res_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			market_open_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			market_open_q <= cfg_data;
		end
	end

	mbpob_front u_front (
		.clk, .arst_n, .push, .full, .command, .symbol, .side, .price, .quantity,
		.participant, .old_price, .old_quantity, .q_empty, .q_pop, .q_head
	);

	mbpob_engine u_engine (
		.clk, .arst_n, .market_open(market_open_q), .q_empty, .q_pop, .q_head,
		.res_full, .res_push, .res_data
	);

	mbpob_resq u_resq (
		.clk, .arst_n, .res_push, .res_data, .res_full, .empty, .pop, .head
	);

	assign status       = head.status;
	assign book_symbol  = head.book_symbol;
	assign bid_entries  = head.bid_entries;
	assign ask_entries  = head.ask_entries;
	assign last_price   = head.last_price;
	assign open_price   = head.open_price;
	assign high_price   = head.high_price;
	assign low_price    = head.low_price;
	assign tick         = head.tick;
	assign trade_count  = head.trade_count;
	assign total_volume = head.total_volume;
	assign notional_sum = head.notional_sum;

	`MBP_ASSERT_NOW(a_fill_bound, clk, arst_n, !empty, (int'(bid_entries) <= ENTRIES) && (int'(ask_entries) <= ENTRIES))
	`MBP_ASSERT_NOW(a_full_has_work, clk, arst_n, full, !q_empty)
	`MBP_ASSERT_NOW(a_no_trade_stats, clk, arst_n, !empty && (trade_count == '0), (last_price == '0) && (high_price == '0) && (low_price == '0) && (tick == TICK_FLAT))

endmodule
